[sv/lru_recency_stack_defines.svh]
// ---------------------------------------------------------------------------
// lru recency stack assertion macros
// Checks that can be compiled out with NO_ASSERTIONS.
// ---------------------------------------------------------------------------
`ifndef LRU_RECENCY_STACK_DEFINES_SVH
`define LRU_RECENCY_STACK_DEFINES_SVH

`ifndef NO_ASSERTIONS
// checked outside reset
`define LRS_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
// checked on every edge
`define LRS_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define LRS_ASSERT(lbl, prop, msg)
`define LRS_ASSERT_ALWAYS(lbl, prop, msg)
`endif

`endif

[sv/lrs_pkg.sv]
// ---------------------------------------------------------------------------
// lru recency stack package
// Shared widths, register codes and the match chain type of the cell row.
// ---------------------------------------------------------------------------
package lrs_pkg;

  localparam int DEPTH_DEFAULT     = 8;
  localparam int KEY_WIDTH_DEFAULT = 32;

  localparam int DATA_W      = 32;  // request_key and evicted_key
  localparam int POS_W       = 3;   // hit_position
  localparam int OCC_W       = 4;   // occupancy
  localparam int CAP_W       = 4;   // capacity_in_use
  localparam int IN_TDATA_W  = 32;
  localparam int OUT_FIELD_W = 1 + POS_W + 1 + DATA_W + OCC_W;
  localparam int OUT_TDATA_W = ((OUT_FIELD_W + 7) / 8) * 8;
  localparam int APB_ADDR_W  = 3;
  localparam int APB_DATA_W  = 32;

  localparam logic [CAP_W-1:0] CAP_RESET = 4'd8;

  typedef enum logic {
    REG_CAPACITY = 1'b0
  } reg_index_t;

  // first-match information rippling down the cell row
  typedef struct packed {
    logic             hit;
    logic [POS_W-1:0] pos;
  } chain_t;

endpackage

[sv/lrs_cell.sv]
// ---------------------------------------------------------------------------
// lru recency stack cell
// One list entry: compares against the request, passes first-match status
// on, and takes its front neighbor's entry when the list shifts.
// ---------------------------------------------------------------------------
module lrs_cell #(
  parameter int KEY_WIDTH = lrs_pkg::KEY_WIDTH_DEFAULT,
  parameter int DEPTH     = lrs_pkg::DEPTH_DEFAULT,
  parameter int INDEX     = 0
) (
  input  logic                              clk,
  input  logic                              load,
  input  logic [KEY_WIDTH-1:0]              key,
  input  logic [KEY_WIDTH-1:0]              prev_entry,
  input  logic [$clog2(DEPTH+1)-1:0]        count_eff,
  input  logic [$clog2(DEPTH+1)-1:0]        top_pos,
  input  lrs_pkg::chain_t                   chain_in,
  output lrs_pkg::chain_t                   chain_out,
  output logic [KEY_WIDTH-1:0]              entry
);
  import lrs_pkg::*;

  localparam int CW = $clog2(DEPTH+1);
  localparam logic [CW-1:0] MY_INDEX = CW'(INDEX);

  logic match;
  logic shift;

  assign match = (MY_INDEX < count_eff) && (entry == key);

  always_comb begin
    chain_out.hit = chain_in.hit | match;
    chain_out.pos = chain_in.hit ? chain_in.pos : POS_W'(INDEX);
  end

  // cells up to the first match (or up to the list top on a miss) move back
  assign shift = !chain_in.hit && (MY_INDEX <= top_pos);

  always_ff @(posedge clk) begin
    if (load && shift) begin
      entry <= prev_entry;
    end
  end

endmodule

[sv/lru_recency_stack.sv]
// LRU recency stack: a move-to-front list of up to capacity_in_use keys held
// in a row of DEPTH cells, most recent key in cell 0. Every request is
// compared in all occupied cells at once; the first match ripples down the
// row, so one item is taken per clock cycle unless the output stalls; its
// result is in the output register from the next cycle. The input side is
// ready whenever the output register is empty or being taken in the same
// cycle. The cycle time is set by the first-match ripple through the cell
// row. Result fields are hit, hit_position, evicted_valid, evicted_key and
// occupancy; capacity values of 0 act as 1 and values above DEPTH as DEPTH.
// ---------------------------------------------------------------------------
// lru recency stack top level
// Cell row, occupancy count, capacity register and output register.
// ---------------------------------------------------------------------------
module lru_recency_stack #(
  parameter int DEPTH     = lrs_pkg::DEPTH_DEFAULT,
  parameter int KEY_WIDTH = lrs_pkg::KEY_WIDTH_DEFAULT
) (
  input  logic                            clk,
  input  logic                            rst,
  // request_key [31:0]
  input  logic [lrs_pkg::IN_TDATA_W-1:0]  s_tdata,
  input  logic                            s_tvalid,
  output logic                            s_tready,
  // hit [0], hit_position [3:1], evicted_valid [4], evicted_key [36:5],
  // occupancy [40:37], zero fill [47:41]
  output logic [lrs_pkg::OUT_TDATA_W-1:0] m_tdata,
  output logic                            m_tvalid,
  input  logic                            m_tready,
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [lrs_pkg::APB_ADDR_W-1:0]  paddr,
  input  logic [lrs_pkg::APB_DATA_W-1:0]  pwdata,
  output logic [lrs_pkg::APB_DATA_W-1:0]  prdata,
  output logic                            pready
);
  import lrs_pkg::*;

  `include "lru_recency_stack_defines.svh"

  localparam int CW  = $clog2(DEPTH+1);
  localparam int EW  = (CW > CAP_W) ? CW : CAP_W;
  localparam int IW  = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int PAD = OUT_TDATA_W - OUT_FIELD_W;

  logic [CAP_W-1:0]     capacity;
  logic [CW-1:0]        count;
  logic [CW-1:0]        count_next;
  logic [EW-1:0]        cap_ext;
  logic [CW-1:0]        cap_eff;
  logic [CW-1:0]        count_eff;
  logic [CW-1:0]        top_pos;
  logic                 full;
  logic                 hit;
  logic                 evict;
  logic                 accept;
  logic [KEY_WIDTH-1:0] key;
  logic [KEY_WIDTH-1:0] entries [DEPTH];
  logic [KEY_WIDTH-1:0] tail_entry;
  logic [POS_W-1:0]     hit_pos;
  logic [DATA_W-1:0]    evicted_key;
  chain_t               chain [DEPTH+1];

  // configuration port
  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      capacity <= CAP_RESET;
    end else if (psel && penable && pwrite && pready && paddr[2] == REG_CAPACITY) begin
      capacity <= pwdata[CAP_W-1:0];
    end
  end

  always_comb begin
    prdata = '0;
    if (paddr[2] == REG_CAPACITY) begin
      prdata = APB_DATA_W'(capacity);
    end
  end

  // effective capacity and occupancy
  assign cap_ext = EW'(capacity);

  always_comb begin
    if (cap_ext == '0) begin
      cap_eff = CW'(1);
    end else if (cap_ext > EW'(DEPTH)) begin
      cap_eff = CW'(DEPTH);
    end else begin
      cap_eff = CW'(cap_ext);
    end
  end

  // a lowered capacity silently drops entries past it
  assign count_eff = (count > cap_eff) ? cap_eff : count;
  assign full      = (count_eff == cap_eff);
  assign top_pos   = full ? (cap_eff - CW'(1)) : count_eff;

  assign key = KEY_WIDTH'($signed(s_tdata[DATA_W-1:0]));

  // cell row
  assign chain[0] = '0;

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic [KEY_WIDTH-1:0] prev_entry;
    if (i == 0) begin : g_front
      assign prev_entry = key;
    end else begin : g_rest
      assign prev_entry = entries[i-1];
    end

    lrs_cell #(
      .KEY_WIDTH (KEY_WIDTH),
      .DEPTH     (DEPTH),
      .INDEX     (i)
    ) u_cell (
      .clk        (clk),
      .load       (accept),
      .key        (key),
      .prev_entry (prev_entry),
      .count_eff  (count_eff),
      .top_pos    (top_pos),
      .chain_in   (chain[i]),
      .chain_out  (chain[i+1]),
      .entry      (entries[i])
    );
  end

  assign hit         = chain[DEPTH].hit;
  assign hit_pos     = hit ? chain[DEPTH].pos : '0;
  assign evict       = !hit && full;
  assign tail_entry  = entries[IW'(cap_eff - CW'(1))];
  assign evicted_key = evict ? DATA_W'(tail_entry) : '0;
  assign count_next  = (!hit && !full) ? (count_eff + CW'(1)) : count_eff;

  // handshake and output register
  assign s_tready = !m_tvalid || m_tready;
  assign accept   = s_tvalid && s_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      count    <= '0;
      m_tvalid <= 1'b0;
    end else begin
      if (accept) begin
        count    <= count_next;
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      m_tdata <= {{PAD{1'b0}}, OCC_W'(count_next), evicted_key, evict, hit_pos, hit};
    end
  end

  `LRS_ASSERT(a_count_in_depth, count <= CW'(DEPTH), "occupancy beyond built depth")
  `LRS_ASSERT(a_accept_gives_result, accept |=> m_tvalid, "accepted item left no result")
  `LRS_ASSERT(a_miss_grows, (accept && !hit && !full) |=> (count == $past(count_eff) + CW'(1)), "miss on a list with room did not grow occupancy")
  `LRS_ASSERT(a_hit_keeps_count, (accept && hit) |=> (count == $past(count_eff)), "hit changed occupancy")
  `LRS_ASSERT(a_evict_excl_hit, (m_tvalid && m_tdata[4]) |-> !m_tdata[0], "eviction reported on a hit")

endmodule

[tb/lru_recency_stack_checker.sv]
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// lru recency stack checker
// Watches the request, result and register channels, keeps its own
// move-to-front list and compares every result with the oldest prediction.
// ---------------------------------------------------------------------------
module lru_recency_stack_checker (
  input  logic                            clk,
  input  logic                            rst,
  input  logic [lrs_pkg::IN_TDATA_W-1:0]  s_tdata,
  input  logic                            s_tvalid,
  input  logic                            s_tready,
  input  logic [lrs_pkg::OUT_TDATA_W-1:0] m_tdata,
  input  logic                            m_tvalid,
  input  logic                            m_tready,
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [lrs_pkg::APB_ADDR_W-1:0]  paddr,
  input  logic [lrs_pkg::APB_DATA_W-1:0]  pwdata,
  input  logic                            pready,
  output int                              mismatch_count,
  output int                              outstanding
);
  import lrs_pkg::*;

  localparam int LIST_DEPTH = DEPTH_DEFAULT;
  localparam logic [APB_ADDR_W-1:0] CAPACITY_ADDR = APB_ADDR_W'(4 * int'(REG_CAPACITY));

  // result fields, hit in the lowest bit
  typedef struct packed {
    logic [OCC_W-1:0]  occupancy;
    logic [DATA_W-1:0] evicted_key;
    logic              evicted_valid;
    logic [POS_W-1:0]  hit_position;
    logic              hit;
  } lru_result_t;

  logic [DATA_W-1:0] recency_list [LIST_DEPTH];
  int                list_count;
  logic [CAP_W-1:0]  capacity;
  lru_result_t       expected_results [$];

  // applies one request to the list and returns the result it should give
  function automatic lru_result_t lru_touch(input logic [DATA_W-1:0] key);
    lru_result_t r;
    int          limit;
    int          top;
    int          i;
    r = '0;
    limit = (capacity == 0) ? 1 : ((capacity > LIST_DEPTH) ? LIST_DEPTH : int'(capacity));
    // lowered capacity drops the tail silently
    if (list_count > limit) list_count = limit;
    for (i = 0; i < list_count; i++) begin
      if (!r.hit && recency_list[i] == key) begin
        r.hit          = 1'b1;
        r.hit_position = POS_W'(i);
      end
    end
    if (r.hit) begin
      top = int'(r.hit_position);
    end else if (list_count == limit) begin
      r.evicted_valid = 1'b1;
      r.evicted_key   = recency_list[limit-1];
      top             = limit - 1;
    end else begin
      top        = list_count;
      list_count = list_count + 1;
    end
    for (i = top; i > 0; i--) recency_list[i] = recency_list[i-1];
    recency_list[0] = key;
    r.occupancy = OCC_W'(list_count);
    return r;
  endfunction

  task automatic check_field(input string field, input logic [DATA_W-1:0] exp_v,
                             input logic [DATA_W-1:0] act_v);
    if (exp_v !== act_v) begin
      $display("[%0t] %s mismatch: expected 0x%0h, actual 0x%0h", $time, field, exp_v, act_v);
      mismatch_count = mismatch_count + 1;
    end
  endtask

  always @(posedge clk) begin : watch
    lru_result_t got;
    lru_result_t want;
    if (rst) begin
      list_count = 0;
      capacity   = CAP_RESET;
      expected_results.delete();
    end else begin
      if (m_tvalid && m_tready) begin
        got = lru_result_t'(m_tdata[OUT_FIELD_W-1:0]);
        if (expected_results.size() == 0) begin
          $display("[%0t] unexpected result: expected none, actual 0x%0h", $time, got);
          mismatch_count = mismatch_count + 1;
        end else begin
          want = expected_results.pop_front();
          check_field("hit", DATA_W'(want.hit), DATA_W'(got.hit));
          check_field("hit_position", DATA_W'(want.hit_position), DATA_W'(got.hit_position));
          check_field("evicted_valid", DATA_W'(want.evicted_valid),
                      DATA_W'(got.evicted_valid));
          check_field("evicted_key", want.evicted_key, got.evicted_key);
          check_field("occupancy", DATA_W'(want.occupancy), DATA_W'(got.occupancy));
        end
      end
      if (s_tvalid && s_tready) expected_results.push_back(lru_touch(s_tdata[DATA_W-1:0]));
      // only the capacity address is modelled; addresses with bit 2 set hold no register
      if (psel && penable && pwrite && pready && paddr == CAPACITY_ADDR)
        capacity = pwdata[CAP_W-1:0];
    end
    outstanding = expected_results.size();
  end

endmodule

[tb/lru_recency_stack_test.sv]
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// lru recency stack testbench
// Directed keys and capacity corners, then random phases over a small key
// pool per capacity so hits, evictions and trims all occur, with stalls.
// ---------------------------------------------------------------------------
module lru_recency_stack_test;
  import lrs_pkg::*;

  localparam int LIST_DEPTH    = DEPTH_DEFAULT;
  localparam int RANDOM_PHASES = 14;
  localparam int PHASE_ITEMS   = 118;
  localparam int QUIET_PHASES  = 3;
  localparam int CYCLE_LIMIT   = 400000;
  localparam logic [APB_ADDR_W-1:0] CAPACITY_ADDR = APB_ADDR_W'(4 * int'(REG_CAPACITY));
  // one past the last register
  localparam logic [APB_ADDR_W-1:0] UNMAPPED_ADDR = APB_ADDR_W'(4 * (int'(REG_CAPACITY) + 1));

  logic                   clk      = 1'b0;
  logic                   rst      = 1'b1;
  logic [IN_TDATA_W-1:0]  s_tdata  = '0;
  logic                   s_tvalid = 1'b0;
  logic                   s_tready;
  logic [OUT_TDATA_W-1:0] m_tdata;
  logic                   m_tvalid;
  logic                   m_tready = 1'b0;
  logic                   psel     = 1'b0;
  logic                   penable  = 1'b0;
  logic                   pwrite   = 1'b0;
  logic [APB_ADDR_W-1:0]  paddr    = '0;
  logic [APB_DATA_W-1:0]  pwdata   = '0;
  logic [APB_DATA_W-1:0]  prdata;
  logic                   pready;

  int          mismatch_count;
  int          outstanding;
  bit          src_idle_on = 1'b1;
  bit          snk_idle_on = 1'b1;
  int          stall_left  = 0;
  int unsigned cycle_count = 0;
  logic [DATA_W-1:0] key_pool [$];

  always #1 clk = ~clk;

  lru_recency_stack u_dut (
    .clk(clk), .rst(rst),
    .s_tdata(s_tdata), .s_tvalid(s_tvalid), .s_tready(s_tready),
    .m_tdata(m_tdata), .m_tvalid(m_tvalid), .m_tready(m_tready),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  lru_recency_stack_checker u_checker (
    .clk(clk), .rst(rst),
    .s_tdata(s_tdata), .s_tvalid(s_tvalid), .s_tready(s_tready),
    .m_tdata(m_tdata), .m_tvalid(m_tvalid), .m_tready(m_tready),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .pready(pready),
    .mismatch_count(mismatch_count), .outstanding(outstanding)
  );

  // result side stalls in bursts of random length
  always @(negedge clk) begin
    if (stall_left > 0) begin
      stall_left = stall_left - 1;
      m_tready <= 1'b0;
    end else if (snk_idle_on && $urandom_range(0, 5) == 0) begin
      stall_left = $urandom_range(0, 10);
      m_tready <= 1'b0;
    end else begin
      m_tready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  task automatic push_key(input logic [DATA_W-1:0] key);
    int gap;
    gap = (src_idle_on && $urandom_range(0, 4) == 0) ? $urandom_range(1, 11) : 0;
    @(negedge clk);
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      s_tdata  <= $urandom;
      repeat (gap) @(negedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= key;
    do @(posedge clk); while (!s_tready);
  endtask

  // stop sending and let every result drain
  task automatic quiesce();
    @(negedge clk);
    s_tvalid <= 1'b0;
    wait (outstanding == 0);
    repeat (2) @(negedge clk);
  endtask

  task automatic write_reg(input logic [APB_ADDR_W-1:0] addr, input logic [APB_DATA_W-1:0] data);
    @(negedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= addr;
    pwdata  <= data;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  // mostly pool keys, some fresh, some one bit away from a pool key, some 0x8000_0000 or 0x7FFF_FFFF
  function automatic logic [DATA_W-1:0] pick_key();
    int                roll;
    logic [DATA_W-1:0] k;
    roll = $urandom_range(0, 99);
    k = key_pool[$urandom_range(0, key_pool.size() - 1)];
    if (roll < 8) k = $urandom;
    else if (roll < 13) k = k ^ (32'd1 << $urandom_range(0, DATA_W - 1));
    else if (roll < 16) k = roll[0] ? 32'h8000_0000 : 32'h7FFF_FFFF;
    return k;
  endfunction

  initial begin
    int                cap_value;
    int                usable;
    logic [DATA_W-1:0] k;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // fill at the reset capacity, then hits at tail, front and middle
    push_key(32'h0000_0000);
    push_key(32'h0000_0001);
    push_key(32'h7FFF_FFFF);
    push_key(32'h8000_0000);
    push_key(32'hFFFF_FFFF);
    push_key(32'h5555_5555);
    push_key(32'hAAAA_AAAA);
    push_key(32'h7FFF_FFFE);
    push_key(32'h0000_0000);
    push_key(32'h0000_0000);
    push_key(32'hFFFF_FFFF);
    push_key(32'h8000_0001);
    push_key(32'h8000_0000);
    quiesce();
    // zero acts as one; the full list gets trimmed to its front key
    write_reg(CAPACITY_ADDR, 32'h0000_0000);
    push_key(32'h8000_0000);
    push_key(32'h1234_5678);
    quiesce();
    // 15 in the low bits, clamps to the depth
    write_reg(CAPACITY_ADDR, 32'hFFFF_FFFF);
    push_key(32'h0F0F_0F0F);
    push_key(32'hF0F0_F0F0);
    push_key(32'h1234_5678);
    push_key(32'h0000_0002);
    push_key(32'h0000_0003);
    push_key(32'h0000_0004);
    quiesce();
    write_reg(UNMAPPED_ADDR, 32'h0000_0001);
    push_key(32'h0000_0005);
    push_key(32'h0000_0006);
    push_key(32'h0000_0007);
    quiesce();

    for (int p = 0; p < RANDOM_PHASES; p++) begin
      case (p)
        0:       cap_value = 1;
        1:       cap_value = 8;
        2:       cap_value = 0;
        3:       cap_value = 15;
        4:       cap_value = 2;
        5:       cap_value = 5;
        default: cap_value = $urandom_range(0, 15);
      endcase
      src_idle_on = (p < RANDOM_PHASES - QUIET_PHASES) && (p % 4 != 1);
      snk_idle_on = (p < RANDOM_PHASES - QUIET_PHASES) && (p % 4 != 2);
      write_reg(CAPACITY_ADDR, ($urandom & ~32'hF) | APB_DATA_W'(cap_value));
      // pool as large as the list or a little larger, so both hits and evictions come
      usable = (cap_value == 0) ? 1 : ((cap_value > LIST_DEPTH) ? LIST_DEPTH : cap_value);
      key_pool.delete();
      repeat (usable + $urandom_range(0, 3)) begin
        k = $urandom;
        if ($urandom_range(0, 7) == 0) k = $urandom_range(0, 1) ? 32'h8000_0000 : 32'hFFFF_FFFF;
        key_pool.push_back(k);
      end
      repeat (PHASE_ITEMS) push_key(pick_key());
      quiesce();
    end

    repeat (8) @(posedge clk);
    if (mismatch_count == 0 && outstanding == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

[filelist.f]
+incdir+sv
sv/lrs_pkg.sv
sv/lrs_cell.sv
sv/lru_recency_stack.sv
tb/lru_recency_stack_checker.sv
tb/lru_recency_stack_test.sv
